// ===== rtl/sns_pkg.sv =====
// sns_pkg: SHA-256 constants, word types and round/schedule functions
// for the double SHA-256 nonce search unit. No dependencies.
`default_nettype none
package sns_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0]  hstate_t;
  typedef word_t [15:0] wwin_t;

  localparam int NumRounds = 64;

  localparam word_t RK [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t IV [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t PadWord   = 32'h80000000;
  localparam word_t Len640    = 32'd640;
  localparam word_t Len256    = 32'd256;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bswap(input word_t x);
    bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  // One compression round; element 0 is a, element 7 is h.
  function automatic hstate_t sha_round(input hstate_t st, input word_t k, input word_t w);
    word_t t1;
    word_t t2;
    hstate_t nx;
    t1 = st[7] + (rotr(st[4], 6) ^ rotr(st[4], 11) ^ rotr(st[4], 25))
         + ((st[4] & st[5]) ^ (~st[4] & st[6])) + k + w;
    t2 = (rotr(st[0], 2) ^ rotr(st[0], 13) ^ rotr(st[0], 22))
         + ((st[0] & st[1]) ^ (st[0] & st[2]) ^ (st[1] & st[2]));
    nx[7] = st[6];
    nx[6] = st[5];
    nx[5] = st[4];
    nx[4] = st[3] + t1;
    nx[3] = st[2];
    nx[2] = st[1];
    nx[1] = st[0];
    nx[0] = t1 + t2;
    sha_round = nx;
  endfunction

  // Slide the schedule window by one word; element 0 is the current word.
  function automatic wwin_t sched_shift(input wwin_t w);
    wwin_t nx;
    word_t s0;
    word_t s1;
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    for (int i = 0; i < 15; i++) nx[i] = w[i + 1];
    nx[15] = w[0] + s0 + w[9] + s1;
    sched_shift = nx;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sns_if.sv =====
// sns_in_if / sns_out_if: valid/ready channels for run requests and results.
// No dependencies.
`default_nettype none
interface sns_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_nonce;
  logic        run_enable;
  modport source (output valid, start_nonce, run_enable, input ready);
  modport sink   (input valid, start_nonce, run_enable, output ready);
endinterface

interface sns_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] next_nonce;
  logic [16:0] hash_count;
  logic [63:0] digest_word_0;
  logic [63:0] digest_word_1;
  logic [63:0] digest_word_2;
  logic [63:0] digest_word_3;
  modport source (output valid, found, next_nonce, hash_count, digest_word_0,
                  digest_word_1, digest_word_2, digest_word_3, input ready);
  modport sink   (input valid, found, next_nonce, hash_count, digest_word_0,
                  digest_word_1, digest_word_2, digest_word_3, output ready);
endinterface
`default_nettype wire

// ===== rtl/sha256d_nonce_search_unit.sv =====
// A disabled run presents its result in the cycle after acceptance. An enabled run
// issues one nonce per cycle into a 130-stage unrolled double SHA-256
// pipeline (input stage, first-block rounds, feed-forward stage, second-block
// rounds) until a hit or the next nonce multiple of 2^YIELD_BITS ends the run.
// One run at a time: the next request is taken only after the result is accepted.
// Reset (synchronous, active low) clears state, issue flag, valid bits and config regs.
// Depends on sns_pkg and sns_if.
`default_nettype none
module sha256d_nonce_search_unit #(
  parameter int YIELD_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  sns_in_if.sink           in_ch,
  sns_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [5:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic      [63:0] cfg_prdata,
  output logic             cfg_pready
);
  import sns_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  localparam logic [2:0] RegMidA = 3'd0;
  localparam logic [2:0] RegMidB = 3'd1;
  localparam logic [2:0] RegMidC = 3'd2;
  localparam logic [2:0] RegMidD = 3'd3;
  localparam logic [2:0] RegTail = 3'd4;
  localparam logic [2:0] RegBits = 3'd5;

  localparam logic [31:0] YMask = 32'((64'd1 << YIELD_BITS) - 64'd1);
  localparam int Last = 2 * NumRounds + 1;  // index of last pipeline stage

  // configuration
  logic [63:0] mid_a_r, mid_b_r, mid_c_r, mid_d_r, tail_r;
  logic [31:0] bits_r;
  logic [2:0]  cfg_idx;
  logic        cfg_wr;

  assign cfg_idx    = cfg_paddr[5:3];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_a_r <= '0; mid_b_r <= '0; mid_c_r <= '0; mid_d_r <= '0;
      tail_r  <= '0; bits_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegMidA: mid_a_r <= cfg_pwdata;
        RegMidB: mid_b_r <= cfg_pwdata;
        RegMidC: mid_c_r <= cfg_pwdata;
        RegMidD: mid_d_r <= cfg_pwdata;
        RegTail: tail_r  <= cfg_pwdata;
        RegBits: bits_r  <= cfg_pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegMidA: cfg_prdata = mid_a_r;
      RegMidB: cfg_prdata = mid_b_r;
      RegMidC: cfg_prdata = mid_c_r;
      RegMidD: cfg_prdata = mid_d_r;
      RegTail: cfg_prdata = tail_r;
      RegBits: cfg_prdata = {32'd0, bits_r};
      default: cfg_prdata = '0;
    endcase
  end

  hstate_t mid;
  assign mid = {mid_d_r[31:0], mid_d_r[63:32], mid_c_r[31:0], mid_c_r[63:32],
                mid_b_r[31:0], mid_b_r[63:32], mid_a_r[31:0], mid_a_r[63:32]};

  // control
  logic [1:0]  state_r, state_nxt;
  logic        issuing_r, issuing_nxt;
  logic [31:0] issue_nonce_r, issue_nonce_nxt;
  logic [16:0] count_r, count_nxt;
  logic        flush;

  logic        found_r;
  logic [31:0] next_nonce_r;
  logic [16:0] hashes_r;
  logic [63:0] dw0_r, dw1_r, dw2_r, dw3_r;

  // pipeline
  hstate_t     st_r    [0:Last];
  wwin_t       win_r   [0:Last];
  logic [31:0] nonce_r [0:Last];
  logic        vld_r   [0:Last];

  hstate_t dg;
  logic    hit;
  logic    at_end;
  logic [31:0] nonce_inc;

  always_comb begin
    for (int i = 0; i < 8; i++) dg[i] = st_r[Last][i] + IV[i];
  end
  assign hit       = (dg[7][15:0] == 16'd0);
  assign nonce_inc = nonce_r[Last] + 32'd1;
  assign at_end    = ((nonce_inc & YMask) == 32'd0);
  assign flush     = (state_r == StRun) && vld_r[Last] && (hit || at_end);

  assign in_ch.ready = (state_r == StIdle);
  assign out_ch.valid = (state_r == StDone);
  assign out_ch.found = found_r;
  assign out_ch.next_nonce = next_nonce_r;
  assign out_ch.hash_count = hashes_r;
  assign out_ch.digest_word_0 = dw0_r;
  assign out_ch.digest_word_1 = dw1_r;
  assign out_ch.digest_word_2 = dw2_r;
  assign out_ch.digest_word_3 = dw3_r;

  always_comb begin
    state_nxt       = state_r;
    issuing_nxt     = issuing_r;
    issue_nonce_nxt = issue_nonce_r;
    count_nxt       = count_r;
    case (state_r)
      StIdle: begin
        if (in_ch.valid) begin
          issue_nonce_nxt = in_ch.start_nonce;
          count_nxt       = '0;
          issuing_nxt     = in_ch.run_enable;
          state_nxt       = in_ch.run_enable ? StRun : StDone;
        end
      end
      StRun: begin
        if (issuing_r) begin
          issue_nonce_nxt = issue_nonce_r + 32'd1;
          if (((issue_nonce_r + 32'd1) & YMask) == 32'd0) issuing_nxt = 1'b0;
        end
        if (vld_r[Last]) count_nxt = count_r + 17'd1;
        if (flush) begin
          issuing_nxt = 1'b0;
          state_nxt   = StDone;
        end
      end
      StDone: begin
        if (out_ch.ready) state_nxt = StIdle;
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= StIdle;
      issuing_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      issuing_r <= issuing_nxt;
    end
    issue_nonce_r <= issue_nonce_nxt;
    count_r       <= count_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == StIdle && in_ch.valid && !in_ch.run_enable) begin
      found_r      <= 1'b0;
      next_nonce_r <= in_ch.start_nonce;
      hashes_r     <= '0;
      dw0_r <= '0; dw1_r <= '0; dw2_r <= '0; dw3_r <= '0;
    end else if (flush) begin
      found_r      <= hit;
      next_nonce_r <= nonce_inc;
      hashes_r     <= count_r + 17'd1;
      dw0_r <= hit ? {dg[0], dg[1]} : 64'd0;
      dw1_r <= hit ? {dg[2], dg[3]} : 64'd0;
      dw2_r <= hit ? {dg[4], dg[5]} : 64'd0;
      dw3_r <= hit ? {dg[6], dg[7]} : 64'd0;
    end
  end

  // stage 0: first block of the second header half
  always_ff @(posedge clk) begin
    st_r[0]    <= mid;
    win_r[0]   <= {Len640, {10{32'd0}}, PadWord, bswap(issue_nonce_r), bits_r,
                   tail_r[31:0], tail_r[63:32]};
    nonce_r[0] <= issue_nonce_r;
    if (!rst_n) vld_r[0] <= 1'b0;
    else        vld_r[0] <= issuing_r && (state_r == StRun) && !flush;
  end

  for (genvar s = 0; s < NumRounds; s++) begin : g_blk1
    always_ff @(posedge clk) begin
      st_r[s + 1]    <= sha_round(st_r[s], RK[s], win_r[s][0]);
      win_r[s + 1]   <= sched_shift(win_r[s]);
      nonce_r[s + 1] <= nonce_r[s];
      if (!rst_n || flush) vld_r[s + 1] <= 1'b0;
      else                 vld_r[s + 1] <= vld_r[s];
    end
  end

  // feed-forward of the first hash; second block starts from IV
  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      st_r[NumRounds + 1][i]  <= IV[i];
      win_r[NumRounds + 1][i] <= st_r[NumRounds][i] + mid[i];
    end
    win_r[NumRounds + 1][8]  <= PadWord;
    for (int i = 9; i < 15; i++) win_r[NumRounds + 1][i] <= '0;
    win_r[NumRounds + 1][15] <= Len256;
    nonce_r[NumRounds + 1] <= nonce_r[NumRounds];
    if (!rst_n || flush) vld_r[NumRounds + 1] <= 1'b0;
    else                 vld_r[NumRounds + 1] <= vld_r[NumRounds];
  end

  for (genvar s = 0; s < NumRounds; s++) begin : g_blk2
    localparam int P = NumRounds + 1 + s;
    always_ff @(posedge clk) begin
      st_r[P + 1]    <= sha_round(st_r[P], RK[s], win_r[P][0]);
      win_r[P + 1]   <= sched_shift(win_r[P]);
      nonce_r[P + 1] <= nonce_r[P];
      if (!rst_n || flush) vld_r[P + 1] <= 1'b0;
      else                 vld_r[P + 1] <= vld_r[P];
    end
  end

endmodule
`default_nettype wire

// ===== tb/sha256d_nonce_search_unit_tb.sv =====
// Testbench for sha256d_nonce_search_unit: drives run requests and APB config,
// predicts run results with its own double SHA-256 search. Needs sns_pkg, sns_if.
`default_nettype none
module sha256d_nonce_search_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sns_pkg::*;

  localparam int YieldBits = 16;
  localparam int IdleLimit = 300000;
  localparam int TailWait  = 200;
  localparam int NumRegs   = 6;
  localparam logic [5:0] AddrUnused0 = 6'd48;
  localparam logic [5:0] AddrUnused1 = 6'd56;
  localparam word_t Hk [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam word_t Hinit [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum int {
    RegMidA = 0, RegMidB = 1, RegMidC = 2, RegMidD = 3, RegTailMt = 4, RegTailBits = 5
  } reg_idx_e;

  typedef struct packed {
    logic              found;
    logic [31:0]       next_nonce;
    logic [16:0]       hash_count;
    logic [3:0][63:0]  digest;
  } search_res_t;

  typedef struct packed {
    logic [31:0] nonce;
    logic        en;
    logic        typed;
  } run_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [5:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  sns_in_if  in_ch();
  sns_out_if out_ch();

  sha256d_nonce_search_unit #(.YIELD_BITS(YieldBits)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  logic [63:0] mid_q [0:3];
  logic [63:0] tail_mt_q;
  logic [31:0] tail_bits_q;
  search_res_t pending_runs [$];
  int errs = 0;
  int idle_cnt = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic word_t ror32(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [7:0][31:0] compress_blk(logic [7:0][31:0] st,
                                                    logic [15:0][31:0] blk);
    word_t w [0:63];
    word_t a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = {st[0], st[1], st[2], st[3], st[4], st[5], st[6], st[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + Hk[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    st[0] += a; st[1] += b; st[2] += c; st[3] += d;
    st[4] += e; st[5] += f; st[6] += g; st[7] += h;
    return st;
  endfunction

  function automatic logic [7:0][31:0] header_hash2(word_t nonce);
    logic [7:0][31:0]  st;
    logic [15:0][31:0] blk;
    for (int i = 0; i < 4; i++) begin
      st[2*i]   = mid_q[i][63:32];
      st[2*i+1] = mid_q[i][31:0];
    end
    blk = '0;
    blk[0] = tail_mt_q[63:32];
    blk[1] = tail_mt_q[31:0];
    blk[2] = tail_bits_q;
    blk[3] = {nonce[7:0], nonce[15:8], nonce[23:16], nonce[31:24]};
    blk[4] = 32'h80000000;
    blk[15] = 32'd640;
    st = compress_blk(st, blk);
    blk = '0;
    for (int i = 0; i < 8; i++) blk[i] = st[i];
    blk[8] = 32'h80000000;
    blk[15] = 32'd256;
    for (int i = 0; i < 8; i++) st[i] = Hinit[i];
    return compress_blk(st, blk);
  endfunction

  function automatic search_res_t predict_search(word_t nonce, logic en);
    search_res_t r;
    logic [7:0][31:0] dg;
    int unsigned cnt;
    r = '0;
    cnt = 0;
    dg = '0;
    if (en) begin
      forever begin
        dg = header_hash2(nonce);
        cnt++;
        nonce = nonce + 1;
        if (dg[7][15:0] == 16'h0) begin
          r.found = 1'b1;
          break;
        end
        if (nonce[YieldBits-1:0] == '0) break;
      end
      if (r.found)
        for (int i = 0; i < 4; i++) r.digest[i] = {dg[2*i], dg[2*i+1]};
    end
    r.next_nonce = nonce;
    r.hash_count = cnt[16:0];
    return r;
  endfunction

  task automatic report_mismatch(string fld, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h", fld, got, want);
    errs++;
  endtask

  // result checker
  always @(posedge clk) begin
    search_res_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_runs.size() == 0) begin
        report_mismatch("unexpected item", 64'(out_ch.next_nonce), '0);
      end else begin
        w = pending_runs.pop_front();
        if (out_ch.found !== w.found)
          report_mismatch("found", 64'(out_ch.found), 64'(w.found));
        if (out_ch.next_nonce !== w.next_nonce)
          report_mismatch("next_nonce", 64'(out_ch.next_nonce), 64'(w.next_nonce));
        if (out_ch.hash_count !== w.hash_count)
          report_mismatch("hash_count", 64'(out_ch.hash_count), 64'(w.hash_count));
        if (out_ch.digest_word_0 !== w.digest[0])
          report_mismatch("digest_word_0", out_ch.digest_word_0, w.digest[0]);
        if (out_ch.digest_word_1 !== w.digest[1])
          report_mismatch("digest_word_1", out_ch.digest_word_1, w.digest[1]);
        if (out_ch.digest_word_2 !== w.digest[2])
          report_mismatch("digest_word_2", out_ch.digest_word_2, w.digest[2]);
        if (out_ch.digest_word_3 !== w.digest[3])
          report_mismatch("digest_word_3", out_ch.digest_word_3, w.digest[3]);
      end
    end
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IdleLimit) begin
      $display("sha256d_nonce_search_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic cfg_write(logic [5:0] addr, logic [63:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (addr >> 3)
      RegMidA:     mid_q[0] = data;
      RegMidB:     mid_q[1] = data;
      RegMidC:     mid_q[2] = data;
      RegMidD:     mid_q[3] = data;
      RegTailMt:   tail_mt_q = data;
      RegTailBits: tail_bits_q = data[31:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_run(logic [31:0] nonce, logic en, logic typed);
    search_res_t r;
    in_ch.valid <= 1'b1;
    in_ch.start_nonce <= nonce;
    in_ch.run_enable <= en;
    do @(posedge clk); while (!in_ch.ready);
    if (typed) begin
      // disabled run: nothing hashed, nonce returned unchanged
      r = '0;
      r.next_nonce = nonce;
    end else begin
      r = predict_search(nonce, en);
    end
    pending_runs.push_back(r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain_runs();
    in_ch.valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] short_run_nonce();
    // low bits near the yield boundary keep runs short
    return {16'($urandom_range(0, 16'hFFFF)), 8'hFF, 8'($urandom_range(0, 255))};
  endfunction

  run_row_t dir_rows [0:12] = '{
    '{32'h00000000, 1'b0, 1'b1}, '{32'hFFFFFFFF, 1'b0, 1'b1}, '{32'h5A5A5A5A, 1'b0, 1'b1},
    '{32'hFFFFFFFF, 1'b1, 1'b0}, '{32'h0000FFFF, 1'b1, 1'b0}, '{32'h8000FFFE, 1'b1, 1'b0},
    '{32'h7FFFFFF0, 1'b1, 1'b0}, '{32'hA5A5FF00, 1'b1, 1'b0}, '{32'h00000000, 1'b1, 1'b0},
    '{32'hFFFFFFFF, 1'b0, 1'b1}, '{32'hFFFFFFFF, 1'b1, 1'b1 ^ 1'b1},
    '{32'h12340000, 1'b1, 1'b0}, '{32'hFFFEFFFF, 1'b1, 1'b0}
  };

  initial begin
    in_ch.valid = 1'b0;
    in_ch.start_nonce = '0;
    in_ch.run_enable = 1'b0;
    for (int i = 0; i < 4; i++) mid_q[i] = '0;
    tail_mt_q = '0;
    tail_bits_q = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 13; i++) begin
      if (i == 9) begin
        drain_runs();
        for (int k = 0; k < NumRegs; k++) cfg_write(6'(k * 8), '1);
        cfg_write(AddrUnused0, {$urandom, $urandom});
        cfg_write(AddrUnused1, {$urandom, $urandom});
      end
      send_run(dir_rows[i].nonce, dir_rows[i].en, dir_rows[i].typed);
    end
    drain_runs();

    for (int ph = 0; ph < 4; ph++) begin
      quiet = (ph == 3);
      for (int k = 0; k < NumRegs; k++) cfg_write(6'(k * 8), {$urandom, $urandom});
      if ($urandom_range(0, 1)) cfg_write(AddrUnused0, {$urandom, $urandom});
      for (int n = 0; n < 25; n++)
        send_run(short_run_nonce(), $urandom_range(0, 4) != 0, 1'b0);
      drain_runs();
    end

    repeat (TailWait) @(posedge clk);
    if (errs == 0)
      $display("sha256d_nonce_search_unit_tb: done, clean");
    else
      $display("sha256d_nonce_search_unit_tb: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
